### hdl/bad_pkg.sv
// bad_pkg: shared types and codes for the box-average downscaler.
// Used by bad_front, bad_back and the top level; has no dependencies.
package bad_pkg;

    localparam int CH_W      = 8;
    localparam int ROW_W     = 10;
    localparam int COL_OUT_W = 10;
    localparam int CFG_W     = 11;
    localparam int TW_REG_W  = 11;
    localparam int SC_REG_W  = 5;
    localparam int IDX_W     = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_TARGET_WIDTH = 2'd0,
        CFG_SCALE_X      = 2'd1,
        CFG_SCALE_Y      = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pixel_t;

    // Per-item classification produced by the front end
    typedef struct packed {
        logic first;
        logic emit;
    } op_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_ADD,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

### hdl/bad_front.sv
// bad_front: block position counters; classifies each item as first,
// accumulate or emit. Depends on bad_pkg.
module bad_front #(
    parameter int COL_W = 10,
    parameter int CB_W  = 4,
    parameter int TW_W  = 11,
    parameter int SC_W  = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         frame_start,
    input  logic [TW_W-1:0]              tw_lim,
    input  logic [SC_W-1:0]              sx_lim,
    input  logic [SC_W-1:0]              sy_lim,
    output bad_pkg::op_ctl_t             ctl,
    output logic [bad_pkg::ROW_W-1:0]    row,
    output logic [COL_W-1:0]             col
);

    logic [CB_W-1:0]           cib_reg, cib_next, cib_cur;
    logic [CB_W-1:0]           rib_reg, rib_next, rib_cur;
    logic [COL_W-1:0]          tcc_reg, tcc_next, tcc_cur;
    logic [bad_pkg::ROW_W-1:0] trc_reg, trc_next, trc_cur;
    logic                      last_col, last_row, last_tcol;

    // Frame start clears the counters before this item
    always_comb
    begin
        cib_cur = frame_start ? '0 : cib_reg;
        rib_cur = frame_start ? '0 : rib_reg;
        tcc_cur = frame_start ? '0 : tcc_reg;
        trc_cur = frame_start ? '0 : trc_reg;
    end

    assign last_col  = (32'(cib_cur) + 32'd1) >= 32'(sx_lim);
    assign last_row  = (32'(rib_cur) + 32'd1) >= 32'(sy_lim);
    assign last_tcol = (32'(tcc_cur) + 32'd1) >= 32'(tw_lim);

    assign ctl.first = (cib_cur == '0) && (rib_cur == '0);
    assign ctl.emit  = last_col && last_row;
    assign row       = trc_cur;
    assign col       = tcc_cur;

    // Counter advance
    always_comb
    begin
        cib_next = cib_cur + CB_W'(1);
        rib_next = rib_cur;
        tcc_next = tcc_cur;
        trc_next = trc_cur;
        if (last_col)
        begin
            cib_next = '0;
            if (last_tcol)
            begin
                tcc_next = '0;
                if (last_row)
                begin
                    rib_next = '0;
                    trc_next = trc_cur + bad_pkg::ROW_W'(1);
                end
                else
                begin
                    rib_next = rib_cur + CB_W'(1);
                end
            end
            else
            begin
                tcc_next = tcc_cur + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cib_reg <= '0;
            rib_reg <= '0;
            tcc_reg <= '0;
            trc_reg <= '0;
        end
        else if (accept)
        begin
            cib_reg <= cib_next;
            rib_reg <= rib_next;
            tcc_reg <= tcc_next;
            trc_reg <= trc_next;
        end
    end

endmodule

### hdl/bad_queue.sv
// bad_queue: small FIFO between front and back ends.
// Generic payload width; no package dependencies.
module bad_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full      = (32'(cnt_reg) == DEPTH);
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + (PW+1)'(1);
        else if (!push && pop)
            cnt_next = cnt_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

endmodule

### hdl/bad_back.sv
// bad_back: line store read-modify-write, bit-serial mean divider and
// output register. Depends on bad_pkg.
module bad_back #(
    parameter int COL_W  = 10,
    parameter int DEPTH  = 1024,
    parameter int AREA_W = 10,
    parameter int SUM_W  = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              op_valid,
    output logic                              op_pop,
    input  bad_pkg::op_ctl_t                  op_ctl,
    input  logic [bad_pkg::ROW_W-1:0]         op_row,
    input  logic [COL_W-1:0]                  op_col,
    input  bad_pkg::pixel_t                   op_px,
    input  logic [AREA_W-1:0]                 area,
    output logic                              res_valid,
    input  logic                              res_ready,
    output bad_pkg::pixel_t                   res_px,
    output logic [bad_pkg::ROW_W-1:0]         res_row,
    output logic [bad_pkg::COL_OUT_W-1:0]     res_col
);

    localparam int DW = SUM_W + bad_pkg::CH_W;

    bad_pkg::back_state_t              state_reg, state_next;
    logic [3:0][SUM_W-1:0]             mem [DEPTH];
    logic [3:0][SUM_W-1:0]             rdata_reg;
    logic [3:0][SUM_W-1:0]             sum_new;
    logic [3:0][SUM_W-1:0]             rem_reg;
    logic [3:0][bad_pkg::CH_W-1:0]     quo_reg;
    logic [3:0][bad_pkg::CH_W-1:0]     px_arr;
    logic [3:0]                        ge;
    logic [DW-1:0]                     dvs;
    logic [2:0]                        step_reg;
    bad_pkg::op_ctl_t                  ctl_reg;
    logic [bad_pkg::ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]                  col_reg;
    bad_pkg::pixel_t                   px_reg;

    assign px_arr = {px_reg.red, px_reg.green, px_reg.blue, px_reg.alpha};

    // New partial sums: first pixel of a block overwrites
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum_new[c] = ctl_reg.first ? SUM_W'(px_arr[c])
                                       : rdata_reg[c] + SUM_W'(px_arr[c]);
        end
    end

    // Restoring divide, one quotient bit per cycle, msb first
    assign dvs = DW'(area) << (~step_reg);
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            ge[c] = DW'(rem_reg[c]) >= dvs;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bad_pkg::BK_IDLE: if (op_valid) state_next = bad_pkg::BK_READ;
            bad_pkg::BK_READ: state_next = bad_pkg::BK_ADD;
            bad_pkg::BK_ADD:  state_next = ctl_reg.emit ? bad_pkg::BK_DIV : bad_pkg::BK_IDLE;
            bad_pkg::BK_DIV:  if (step_reg == 3'd7) state_next = bad_pkg::BK_OUT;
            bad_pkg::BK_OUT:  if (res_ready) state_next = bad_pkg::BK_IDLE;
            default:          state_next = bad_pkg::BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        op_pop    = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            bad_pkg::BK_IDLE: op_pop = op_valid;
            bad_pkg::BK_OUT:  res_valid = 1'b1;
            default:          ;
        endcase
    end

    assign res_px  = {quo_reg[3], quo_reg[2], quo_reg[1], quo_reg[0]};
    assign res_row = row_reg;
    assign res_col = bad_pkg::COL_OUT_W'(col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bad_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Line store
    always_ff @(posedge clk)
    begin
        if (state_reg == bad_pkg::BK_READ)
            rdata_reg <= mem[col_reg];
        if (state_reg == bad_pkg::BK_ADD)
            mem[col_reg] <= sum_new;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            ctl_reg <= op_ctl;
            row_reg <= op_row;
            col_reg <= op_col;
            px_reg  <= op_px;
        end
        if (state_reg == bad_pkg::BK_ADD)
        begin
            rem_reg  <= sum_new;
            step_reg <= '0;
        end
        else if (state_reg == bad_pkg::BK_DIV)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (ge[c])
                    rem_reg[c] <= SUM_W'(DW'(rem_reg[c]) - dvs);
                quo_reg[c] <= {quo_reg[c][bad_pkg::CH_W-2:0], ge[c]};
            end
            step_reg <= step_reg + 3'd1;
        end
    end

endmodule

### hdl/box_average_downscale.sv
// box_average_downscale: top level of the integer box-filter downscaler.
// Instantiates bad_front, bad_queue and bad_back; uses bad_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  cfg     | cfg_we               | cfg_index, cfg_data
//  in      | in_valid / in_ready  | frame_start, red/green/blue/alpha_in
//  out     | out_valid / out_ready| red/green/blue/alpha_out, out_row, out_col
//
// The front end takes one item per cycle into a 4-entry queue.
// The back end runs each item through the line-store read-modify-write (pop, read, add),
// and an item that ends a block through the divider and output states, before the next item.
// Input stalls only when the queue is full; output stalls hold the back end.
// Reset clears counters, queue and control; the line store needs no clearing.
module box_average_downscale #(
    parameter int MAX_TARGET_WIDTH = 1024,
    parameter int MAX_SCALE        = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bad_pkg::IDX_W-1:0]         cfg_index,
    input  logic [bad_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              frame_start,
    input  logic [bad_pkg::CH_W-1:0]          red_in,
    input  logic [bad_pkg::CH_W-1:0]          green_in,
    input  logic [bad_pkg::CH_W-1:0]          blue_in,
    input  logic [bad_pkg::CH_W-1:0]          alpha_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bad_pkg::CH_W-1:0]          red_out,
    output logic [bad_pkg::CH_W-1:0]          green_out,
    output logic [bad_pkg::CH_W-1:0]          blue_out,
    output logic [bad_pkg::CH_W-1:0]          alpha_out,
    output logic [bad_pkg::ROW_W-1:0]         out_row,
    output logic [bad_pkg::COL_OUT_W-1:0]     out_col
);

    localparam int COL_W  = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;
    localparam int CB_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int TW_W   = $clog2(MAX_TARGET_WIDTH + 1);
    localparam int SC_W   = $clog2(MAX_SCALE + 1);
    localparam int AREA_W = 2 * SC_W;
    localparam int SUM_W  = bad_pkg::CH_W + AREA_W;
    localparam int QW     = $bits(bad_pkg::op_ctl_t) + bad_pkg::ROW_W + COL_W
                            + $bits(bad_pkg::pixel_t);

    logic [bad_pkg::TW_REG_W-1:0] tw_reg;
    logic [bad_pkg::SC_REG_W-1:0] sx_reg, sy_reg;
    logic [TW_W-1:0]              tw_lim;
    logic [SC_W-1:0]              sx_lim, sy_lim;
    logic [AREA_W-1:0]            area;
    logic                         accept, q_full, q_pop, q_valid;
    bad_pkg::op_ctl_t             f_ctl, q_ctl;
    logic [bad_pkg::ROW_W-1:0]    f_row, q_row;
    logic [COL_W-1:0]             f_col, q_col;
    bad_pkg::pixel_t              f_px, q_px, res_px;
    logic [QW-1:0]                q_in, q_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= bad_pkg::TW_REG_W'(1);
            sx_reg <= bad_pkg::SC_REG_W'(1);
            sy_reg <= bad_pkg::SC_REG_W'(1);
        end
        else if (cfg_we)
        begin
            case (bad_pkg::cfg_idx_t'(cfg_index))
                bad_pkg::CFG_TARGET_WIDTH: tw_reg <= cfg_data;
                bad_pkg::CFG_SCALE_X:      sx_reg <= bad_pkg::SC_REG_W'(cfg_data);
                bad_pkg::CFG_SCALE_Y:      sy_reg <= bad_pkg::SC_REG_W'(cfg_data);
                default:                   ;
            endcase
        end
    end

    // Zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (tw_reg == '0)
            tw_lim = TW_W'(1);
        else if (32'(tw_reg) > MAX_TARGET_WIDTH)
            tw_lim = TW_W'(MAX_TARGET_WIDTH);
        else
            tw_lim = TW_W'(tw_reg);
        if (sx_reg == '0)
            sx_lim = SC_W'(1);
        else if (32'(sx_reg) > MAX_SCALE)
            sx_lim = SC_W'(MAX_SCALE);
        else
            sx_lim = SC_W'(sx_reg);
        if (sy_reg == '0)
            sy_lim = SC_W'(1);
        else if (32'(sy_reg) > MAX_SCALE)
            sy_lim = SC_W'(MAX_SCALE);
        else
            sy_lim = SC_W'(sy_reg);
    end

    assign area = AREA_W'(sx_lim) * AREA_W'(sy_lim);

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign f_px     = {red_in, green_in, blue_in, alpha_in};

    bad_front #(
        .COL_W (COL_W),
        .CB_W  (CB_W),
        .TW_W  (TW_W),
        .SC_W  (SC_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (frame_start),
        .tw_lim      (tw_lim),
        .sx_lim      (sx_lim),
        .sy_lim      (sy_lim),
        .ctl         (f_ctl),
        .row         (f_row),
        .col         (f_col)
    );

    assign q_in = {f_ctl, f_row, f_col, f_px};
    assign {q_ctl, q_row, q_col, q_px} = q_out;

    bad_queue #(
        .W     (QW),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_valid)
    );

    bad_back #(
        .COL_W  (COL_W),
        .DEPTH  (MAX_TARGET_WIDTH),
        .AREA_W (AREA_W),
        .SUM_W  (SUM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op_pop    (q_pop),
        .op_ctl    (q_ctl),
        .op_row    (q_row),
        .op_col    (q_col),
        .op_px     (q_px),
        .area      (area),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res_px    (res_px),
        .res_row   (out_row),
        .res_col   (out_col)
    );

    assign red_out   = res_px.red;
    assign green_out = res_px.green;
    assign blue_out  = res_px.blue;
    assign alpha_out = res_px.alpha;

endmodule

### hdl/bad_checker.sv
// bad_checker: port-level assertions for box_average_downscale, bound below.
// Uses only the top-level ports; no package dependencies.
module bad_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_out,
    input logic [9:0] out_col
);

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red_out) && $stable(out_col))
        else $error("result payload changed while stalled");

    // Back end cannot deliver results back to back
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("results delivered back to back");

    // Nothing offered right out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered at reset release");

endmodule

bind box_average_downscale bad_checker u_bad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .out_col   (out_col)
);
